// File: hw/rtl/lpwm_pkg.sv
package lpwm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PWM_PERIOD    = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_QTR = 2'd1;
  localparam logic [1:0] CFG_PRES_THRESH   = 2'd2;

  localparam logic [7:0]  PWM_PERIOD_RST    = 8'd25;
  localparam logic [15:0] TICKS_PER_QTR_RST = 16'd200;
  localparam logic [7:0]  PRES_THRESH_RST   = 8'd150;

  localparam logic [2:0] QTR_PRESENCE = 3'd1;
  localparam logic [2:0] QTR_LIGHT    = 3'd4;

  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam logic [5:0] MINS_PER_HR  = 6'd60;
  localparam logic [4:0] HRS_PER_DAY  = 5'd24;

  // x/10 as x*205 >> 11, exact for 8-bit x
  localparam logic [15:0] DIV10_MUL = 16'd205;
  // x*39/100 as x*(39*5243) >> 19, exact for 8-bit x
  localparam logic [25:0] PCT_MUL   = 26'd204477;

  typedef struct packed {
    logic [7:0] presence_sample;
    logic [7:0] light_sample;
    logic       forced_off;
  } in_t;

  typedef struct packed {
    logic       lamp_level;
    logic [4:0] clock_hours;
    logic [5:0] clock_minutes;
    logic [5:0] clock_seconds;
    logic [6:0] light_percent;
  } out_t;

  typedef struct packed {
    logic [7:0]  pwm_period;
    logic [15:0] ticks_per_quarter;
    logic [7:0]  presence_threshold;
  } cfg_t;

  function automatic logic [4:0] light_to_duty(input logic [7:0] light);
    logic [15:0] prod;
    prod = 16'(light) * DIV10_MUL;
    return prod[15:11];
  endfunction

  function automatic logic [6:0] light_to_pct(input logic [7:0] light);
    logic [25:0] prod;
    prod = 26'(light) * PCT_MUL;
    return prod[25:19];
  endfunction

endpackage

// File: hw/rtl/lpwm_clock.sv
module lpwm_clock
  import lpwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       sec_adv,
  output logic [4:0] hours_nxt,
  output logic [5:0] mins_nxt,
  output logic [5:0] secs_nxt
);

  logic [4:0] hours_r;
  logic [5:0] mins_r;
  logic [5:0] secs_r;

  logic [5:0] sec_inc;
  logic [5:0] min_mid;
  logic [4:0] hr_mid;

  always_comb begin
    sec_inc  = secs_r + 6'd1;
    secs_nxt = secs_r;
    min_mid  = mins_r;
    hr_mid   = hours_r;
    mins_nxt = mins_r;
    hours_nxt = hours_r;
    if (sec_adv) begin
      secs_nxt = sec_inc;
      if (sec_inc >= SECS_PER_MIN) begin
        secs_nxt = '0;
        min_mid  = mins_r + 6'd1;
      end
      mins_nxt = min_mid;
      if (min_mid >= MINS_PER_HR) begin
        mins_nxt = '0;
        hr_mid   = hours_r + 5'd1;
      end
      hours_nxt = hr_mid;
      if (hr_mid >= HRS_PER_DAY) begin
        hours_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r <= '0;
      mins_r  <= '0;
      secs_r  <= '0;
    end else begin
      hours_r <= hours_nxt;
      mins_r  <= mins_nxt;
      secs_r  <= secs_nxt;
    end
  end

endmodule

// File: hw/rtl/lpwm_tick.sv
module lpwm_tick
  import lpwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_t        item,
  input  cfg_t       cfg,
  output logic       lamp_level,
  output logic       sec_adv,
  output logic [6:0] pct_nxt
);

  logic [15:0] div_r, div_nxt;
  logic [2:0]  qtr_r, qtr_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic [4:0]  duty_r, duty_nxt;
  logic [6:0]  pct_r;
  logic [7:0]  pres_r, pres_nxt;

  logic [15:0] div_inc;
  logic [7:0]  phase_inc;
  logic [2:0]  qtr_inc;
  logic        pwm_high;

  always_comb begin
    div_inc   = div_r + 16'd1;
    phase_inc = phase_r + 8'd1;
    qtr_inc   = qtr_r + 3'd1;
    // pwm level uses the advanced phase against the old duty
    pwm_high  = (phase_inc > 8'(duty_r));
    phase_nxt = (phase_inc >= cfg.pwm_period) ? '0 : phase_inc;

    div_nxt  = div_inc;
    qtr_nxt  = qtr_r;
    pres_nxt = pres_r;
    duty_nxt = duty_r;
    pct_nxt  = pct_r;
    sec_adv  = 1'b0;
    if (div_inc >= cfg.ticks_per_quarter) begin
      div_nxt = '0;
      qtr_nxt = qtr_inc;
      if (qtr_inc == QTR_PRESENCE) begin
        pres_nxt = item.presence_sample;
      end
      if (qtr_inc == QTR_LIGHT) begin
        qtr_nxt  = '0;
        sec_adv  = step;
        duty_nxt = light_to_duty(item.light_sample);
        pct_nxt  = light_to_pct(item.light_sample);
      end
    end
    if (!step) begin
      pct_nxt = pct_r;
    end

    if (item.forced_off) begin
      lamp_level = 1'b1;
    end else if (pres_nxt >= cfg.presence_threshold) begin
      lamp_level = pwm_high;
    end else begin
      lamp_level = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= '0;
      qtr_r   <= '0;
      phase_r <= '0;
      duty_r  <= '0;
      pct_r   <= '0;
      pres_r  <= '0;
    end else if (step) begin
      div_r   <= div_nxt;
      qtr_r   <= qtr_nxt;
      phase_r <= phase_nxt;
      duty_r  <= duty_nxt;
      pct_r   <= pct_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule

// File: hw/rtl/light_dimmed_presence_lamp_pwm.sv
// light_dimmed_presence_lamp_pwm
//
// one input item is one timer tick carrying the presence and light converter
// samples and the forced-off mode bit; every tick yields exactly one result
// item with the lamp pin level and the running hh:mm:ss clock and light percent
// as they stand after that tick
//
// channels: in_ (valid/ready, in_t payload), out_ (valid/ready, out_t payload),
// cfg_ (valid/ready write, cfg_index selects pwm period, ticks per quarter or
// presence threshold; cfg_ready is always high, unknown indexes are dropped)
//
// path: an accepted item goes into the input register, then through one pass of
// tick logic into the result register
// throughput: 1 item per cycle while out_ready stays high, bounded only by the
// single tick-logic pass
//
// reset (rst_n low, synchronous): both channel registers empty, all counters,
// latched samples and the clock go to zero, config registers to their defaults
//
// receiver stall: the result register holds its item; the input register takes one
// more item if it is empty, then in_ready drops until out_ready returns
module light_dimmed_presence_lamp_pwm
  import lpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,

  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // input register
  logic in_valid_r;
  in_t  in_data_r;

  // result register
  logic out_valid_r;
  out_t out_data_r;

  // configuration registers
  cfg_t cfg_r;

  // one tick is processed when an item waits and the result slot frees up
  logic step;

  logic       lamp_level;
  logic       sec_adv;
  logic [6:0] pct_nxt;
  logic [4:0] hours_nxt;
  logic [5:0] mins_nxt;
  logic [5:0] secs_nxt;
  out_t       result;

  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lpwm_tick u_tick (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (in_data_r),
    .cfg        (cfg_r),
    .lamp_level (lamp_level),
    .sec_adv    (sec_adv),
    .pct_nxt    (pct_nxt)
  );

  lpwm_clock u_clock (
    .clk       (clk),
    .rst_n     (rst_n),
    .sec_adv   (sec_adv),
    .hours_nxt (hours_nxt),
    .mins_nxt  (mins_nxt),
    .secs_nxt  (secs_nxt)
  );

  always_comb begin
    result.lamp_level    = lamp_level;
    result.clock_hours   = hours_nxt;
    result.clock_minutes = mins_nxt;
    result.clock_seconds = secs_nxt;
    result.light_percent = pct_nxt;
  end

  // input side: load on accept, empty once the tick is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // result side: new item on step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period         <= PWM_PERIOD_RST;
      cfg_r.ticks_per_quarter  <= TICKS_PER_QTR_RST;
      cfg_r.presence_threshold <= PRES_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PWM_PERIOD:    cfg_r.pwm_period         <= cfg_data[7:0];
        CFG_TICKS_PER_QTR: cfg_r.ticks_per_quarter  <= cfg_data;
        CFG_PRES_THRESH:   cfg_r.presence_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/lpwm_chk.sv
module lpwm_chk
  import lpwm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // clock fields stay in their ranges
  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.clock_seconds < SECS_PER_MIN) &&
                  (out_data.clock_minutes < MINS_PER_HR) &&
                  (out_data.clock_hours < HRS_PER_DAY))
    else $error("clock field out of range");

  // percent never exceeds 99
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.light_percent <= 7'd99)
    else $error("light percent out of range");

endmodule

bind light_dimmed_presence_lamp_pwm lpwm_chk u_lpwm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/lamp_tick_checker.sv
`timescale 1ns / 1ps
module lamp_tick_checker
  import lpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned checked
);

  // register copies
  logic [7:0]  period_r;
  logic [15:0] tpq_r;
  logic [7:0]  thresh_r;

  // lamp state
  logic [15:0] tick_div;
  logic [2:0]  qtr;
  logic [7:0]  phase;
  logic [4:0]  duty;
  logic [6:0]  pct;
  logic [7:0]  presence_lat;
  logic [5:0]  secs;
  logic [5:0]  mins;
  logic [4:0]  hours;

  out_t lamp_q[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    checked = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // one timer tick: pwm phase, quarter latches, clock, then lamp pin
  task automatic lamp_tick_predict(input in_t t, output out_t r);
    logic pwm_hi;
    tick_div = tick_div + 16'd1;
    phase = phase + 8'd1;
    pwm_hi = (phase > 8'(duty));
    if (phase >= period_r)
      phase = '0;
    if (tick_div >= tpq_r) begin
      tick_div = '0;
      qtr = qtr + 3'd1;
      if (qtr == QTR_PRESENCE)
        presence_lat = t.presence_sample;
      if (qtr == QTR_LIGHT) begin
        qtr = '0;
        secs = secs + 6'd1;
        if (secs >= SECS_PER_MIN) begin
          secs = '0;
          mins = mins + 6'd1;
        end
        if (mins >= MINS_PER_HR) begin
          mins = '0;
          hours = hours + 5'd1;
        end
        if (hours >= HRS_PER_DAY)
          hours = '0;
        pct = 7'((16'(t.light_sample) * 16'd39) / 16'd100);
        duty = 5'(t.light_sample / 8'd10);
      end
    end
    if (t.forced_off)
      r.lamp_level = 1'b1;
    else if (presence_lat >= thresh_r)
      r.lamp_level = pwm_hi;
    else
      r.lamp_level = 1'b1;
    r.clock_hours = hours;
    r.clock_minutes = mins;
    r.clock_seconds = secs;
    r.light_percent = pct;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      period_r = PWM_PERIOD_RST;
      tpq_r = TICKS_PER_QTR_RST;
      thresh_r = PRES_THRESH_RST;
      tick_div = '0;
      qtr = '0;
      phase = '0;
      duty = '0;
      pct = '0;
      presence_lat = '0;
      secs = '0;
      mins = '0;
      hours = '0;
      lamp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PWM_PERIOD:    period_r = cfg_data[7:0];
          CFG_TICKS_PER_QTR: tpq_r = cfg_data;
          CFG_PRES_THRESH:   thresh_r = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (lamp_q.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = lamp_q.pop_front();
          checked++;
          check_field("lamp_level", 8'(out_data.lamp_level),
                      8'(want.lamp_level));
          check_field("clock_hours", 8'(out_data.clock_hours),
                      8'(want.clock_hours));
          check_field("clock_minutes", 8'(out_data.clock_minutes),
                      8'(want.clock_minutes));
          check_field("clock_seconds", 8'(out_data.clock_seconds),
                      8'(want.clock_seconds));
          check_field("light_percent", 8'(out_data.light_percent),
                      8'(want.light_percent));
        end
      end
      if (in_valid && in_ready) begin
        lamp_tick_predict(in_data, want);
        lamp_q.push_back(want);
      end
    end
    outstanding = lamp_q.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lpwm_pkg::*;

  // index with no register behind it, writes must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // cycles with no item moving on any channel before giving up
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 130;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 0;
  int unsigned stuck_cycles = 0;

  // high for the stretch where neither side idles
  logic       steady;
  // current presence threshold, used to aim presence samples at the compare
  logic [7:0] cur_thresh;

  light_dimmed_presence_lamp_pwm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lamp_tick_checker lamp_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: drops ready about 8 times in a hundred unless in the steady stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady || ($urandom_range(0, 99) >= 8);
    end
  end

  // watchdog on cycles where nothing is accepted anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // starts and ends at a falling edge; valid stays up after the accept so the
  // next item can follow back to back
  task automatic send_tick(input in_t item);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] period, input logic [15:0] tpq,
                                input logic [7:0] thresh);
    write_reg(CFG_PWM_PERIOD, 16'(period));
    write_reg(CFG_TICKS_PER_QTR, tpq);
    write_reg(CFG_PRES_THRESH, 16'(thresh));
    cfg_valid <= 1'b0;
    cur_thresh = thresh;
    settings_used++;
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [7:0]  period;
    logic [15:0] tpq;
    logic [7:0]  thresh;
    in_t         item;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PWM_PERIOD;
    cfg_data = '0;
    steady = 1'b0;
    cur_thresh = PRES_THRESH_RST;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: nothing latched yet, lamp stays off whatever comes in
    send_tick(in_t'{8'd255, 8'd255, 1'b0});
    send_tick(in_t'{8'd0, 8'd0, 1'b1});
    drain();

    // zero ticks per quarter: every tick moves the quarter count, so presence
    // and light are latched within a few ticks; the write to the unused index
    // must leave all registers alone
    write_reg(CFG_UNUSED, 16'hFFFF);
    apply_settings(8'd3, 16'd0, 8'd0);
    for (int i = 0; i < 12; i++)
      send_tick(in_t'{(i < 8) ? 8'd255 : 8'd0,
                      (i < 4) ? 8'd255 : ((i < 8) ? 8'd10 : 8'd9),
                      (i % 4 == 2)});
    drain();

    // zero period: phase wraps every tick; full presence just meets a full threshold
    apply_settings(8'd0, 16'd1, 8'd255);
    for (int i = 0; i < 6; i++)
      send_tick(in_t'{8'd255, (i % 2 == 0) ? 8'd100 : 8'd99, 1'b0});
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        // long counts: full period, full quarter length
        0: begin
          period = 8'd255;
          tpq = 16'hFFFF;
          thresh = 8'($urandom_range(0, 255));
        end
        // both limits dropped below the running phase and divider
        1: begin
          period = 8'd2;
          tpq = 16'd1;
          thresh = 8'd0;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: period = 8'd1;
            1: period = 8'd255;
            default: period = 8'($urandom_range(1, 40));
          endcase
          case ($urandom_range(0, 3))
            0: tpq = 16'd0;
            1: tpq = 16'd1;
            default: tpq = 16'($urandom_range(2, 6));
          endcase
          case ($urandom_range(0, 3))
            0: thresh = 8'd0;
            1: thresh = 8'd255;
            default: thresh = 8'($urandom);
          endcase
        end
      endcase
      apply_settings(period, tpq, thresh);
      // one phase with no idling on either side
      steady <= (p == 2);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender until the pipe is empty, mid phase
        if (p == 4 && i == PHASE_ITEMS / 2)
          drain();
        item.light_sample = 8'($urandom);
        item.forced_off = ($urandom_range(0, 4) == 0);
        // aim presence at both sides of the threshold and the extremes
        case ($urandom_range(0, 5))
          0: item.presence_sample = cur_thresh;
          1: item.presence_sample = cur_thresh - 8'd1;
          2: item.presence_sample = 8'd255;
          3: item.presence_sample = 8'd0;
          default: item.presence_sample = 8'($urandom);
        endcase
        send_tick(item);
      end
      drain();
      steady <= 1'b0;
    end

    // keep idling to catch any stray result
    repeat (8) @(negedge clk);

    $display("sent %0d ticks under %0d register settings, %0d results compared",
             ticks_sent, settings_used, checked);
    $display("settings spanned zero and full periods, zero to full quarter lengths, "
             , "and both threshold ends");
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lpwm_pkg.sv
hw/rtl/lpwm_clock.sv
hw/rtl/lpwm_tick.sv
hw/rtl/light_dimmed_presence_lamp_pwm.sv
hw/rtl/lpwm_chk.sv
tb/sv/lamp_tick_checker.sv
tb/sv/tb.sv
